// File: src/xcpd_pkg.sv
package xcpd_pkg;

    localparam logic [7:0] SYNC_FIRST    = 8'hAA;
    localparam logic [7:0] SYNC_SECOND   = 8'h55;
    localparam logic [7:0] FRAME_VERSION = 8'h01;

    // Register indexes on the configuration port (byte address bit 2).
    localparam logic REG_TYPE_FLOOR   = 1'b0;
    localparam logic REG_TYPE_CEILING = 1'b1;

    typedef enum logic [2:0] {
        ST_CONSUMED  = 3'd0,
        ST_PACKET_OK = 3'd1,
        ST_OVERWRITE = 3'd2,
        ST_PARSE_ERR = 3'd3,
        ST_CHECK_ERR = 3'd4,
        ST_NONE      = 3'd5,
        ST_DATA      = 3'd6
    } t_status;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TAKE = 1'b1
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
    } t_cmd;

    typedef struct packed {
        logic [7:0] type_floor;
        logic [7:0] type_ceiling;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic        has_packet;
        logic [7:0]  msg_type;
        logic [5:0]  payload_length;
        logic [7:0]  payload_byte;
        logic [4:0]  byte_position;
        logic        last;
        logic [31:0] parse_error_count;
        logic [31:0] checksum_error_count;
        logic [31:0] received_count;
        logic [31:0] overwritten_count;
    } t_result;

endpackage

// File: src/xcpd_item_if.sv
interface xcpd_item_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

// File: src/xcpd_result_if.sv
interface xcpd_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        has_packet;
    logic [7:0]  msg_type;
    logic [5:0]  payload_length;
    logic [7:0]  payload_byte;
    logic [4:0]  byte_position;
    logic        last;
    logic [31:0] parse_error_count;
    logic [31:0] checksum_error_count;
    logic [31:0] received_count;
    logic [31:0] overwritten_count;

    modport source (
        output valid, output status, output has_packet, output msg_type,
        output payload_length, output payload_byte, output byte_position, output last,
        output parse_error_count, output checksum_error_count, output received_count,
        output overwritten_count, input ready
    );
    modport sink (
        input valid, input status, input has_packet, input msg_type,
        input payload_length, input payload_byte, input byte_position, input last,
        input parse_error_count, input checksum_error_count, input received_count,
        input overwritten_count, output ready
    );
endinterface

// File: src/xcpd_front.sv
module xcpd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    xcpd_item_if.sink      i_item,
    output logic           o_cmd_valid,
    output xcpd_pkg::t_cmd o_cmd,
    input  logic           i_cmd_pop
);
    import xcpd_pkg::*;

    // Two-entry queue of classified commands.
    t_cmd       r_queue [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       push;
    t_cmd       cmd_in;

    assign i_item.ready = (r_count != 2'd2);
    assign push         = i_item.valid && i_item.ready;
    assign cmd_in.op    = i_item.operation ? OP_TAKE : OP_BYTE;
    assign cmd_in.rx_byte = i_item.rx_byte;

    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_queue[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_cmd_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !i_cmd_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_cmd_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd_in;
        end
    end
endmodule

// File: src/xcpd_back.sv
module xcpd_back #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  xcpd_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    input  xcpd_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    xcpd_result_if.source  o_result
);
    import xcpd_pkg::*;

    localparam int DEPTH = 2 * MAX_PAYLOAD;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [6:0] {
        PH_SYNC0   = 7'b0000001,
        PH_SYNC1   = 7'b0000010,
        PH_VERSION = 7'b0000100,
        PH_TYPE    = 7'b0001000,
        PH_LENGTH  = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_CHECK   = 7'b1000000
    } t_phase;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_EMIT = 2'b10
    } t_bstate;

    // Parser state
    t_phase      r_phase,     n_phase;
    logic [7:0]  r_xor,       n_xor;
    logic [7:0]  r_pend_type, n_pend_type;
    logic [5:0]  r_pend_len,  n_pend_len;
    logic [5:0]  r_pend_pos,  n_pend_pos;
    // Held packet
    logic        r_held_bank, n_held_bank;
    logic [7:0]  r_held_type, n_held_type;
    logic [5:0]  r_held_len,  n_held_len;
    logic        r_held_valid, n_held_valid;
    // Counters
    logic [31:0] r_cnt_parse, n_cnt_parse;
    logic [31:0] r_cnt_check, n_cnt_check;
    logic [31:0] r_cnt_recv,  n_cnt_recv;
    logic [31:0] r_cnt_over,  n_cnt_over;
    // Take sequencer and output register
    t_bstate     r_state,     n_state;
    logic [5:0]  r_emit_pos,  n_emit_pos;
    logic        r_out_valid, n_out_valid;
    t_result     r_res,       n_res;

    // Payload memory: two banks, one being filled while the other is held.
    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] fill_base;
    logic [AW-1:0] held_base;

    logic       slot_free;
    logic       do_byte;
    logic       do_take;
    logic [7:0] b;
    t_status    st;
    logic [5:0] pos_inc;
    logic [5:0] emit_next;

    assign slot_free = !r_out_valid || o_result.ready;
    assign do_byte   = (r_state == B_IDLE) && i_cmd_valid && slot_free && (i_cmd.op == OP_BYTE);
    assign do_take   = (r_state == B_IDLE) && i_cmd_valid && slot_free && (i_cmd.op == OP_TAKE);
    assign o_cmd_pop = do_byte || do_take;
    assign b         = i_cmd.rx_byte;
    assign fill_base = r_held_bank ? '0 : AW'(MAX_PAYLOAD);
    assign held_base = r_held_bank ? AW'(MAX_PAYLOAD) : '0;
    assign pos_inc   = r_pend_pos + 6'd1;
    assign emit_next = r_emit_pos + 6'd1;

    always_comb begin
        n_phase      = r_phase;
        n_xor        = r_xor;
        n_pend_type  = r_pend_type;
        n_pend_len   = r_pend_len;
        n_pend_pos   = r_pend_pos;
        n_held_bank  = r_held_bank;
        n_held_type  = r_held_type;
        n_held_len   = r_held_len;
        n_held_valid = r_held_valid;
        n_cnt_parse  = r_cnt_parse;
        n_cnt_check  = r_cnt_check;
        n_cnt_recv   = r_cnt_recv;
        n_cnt_over   = r_cnt_over;
        n_state      = r_state;
        n_emit_pos   = r_emit_pos;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_res        = r_res;
        st           = ST_CONSUMED;
        wr_en        = 1'b0;
        wr_addr      = fill_base + AW'(r_pend_pos);
        rd_en        = 1'b0;
        rd_addr      = held_base;

        if (do_byte) begin
            case (r_phase)
                PH_SYNC0: begin
                    if (b == SYNC_FIRST) begin
                        n_phase = PH_SYNC1;
                    end
                end
                PH_SYNC1: begin
                    if (b == SYNC_SECOND) begin
                        n_phase = PH_VERSION;
                    end else if (b != SYNC_FIRST) begin
                        n_phase = PH_SYNC0;
                        n_xor = '0; n_pend_type = '0; n_pend_len = '0; n_pend_pos = '0;
                    end
                end
                PH_VERSION: begin
                    if (b != FRAME_VERSION) begin
                        n_cnt_parse = r_cnt_parse + 32'd1;
                        st = ST_PARSE_ERR;
                        n_phase = PH_SYNC0;
                        n_xor = '0; n_pend_type = '0; n_pend_len = '0; n_pend_pos = '0;
                    end else begin
                        n_xor   = b;
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    if (b <= i_cfg.type_floor || b >= i_cfg.type_ceiling) begin
                        n_cnt_parse = r_cnt_parse + 32'd1;
                        st = ST_PARSE_ERR;
                        n_phase = PH_SYNC0;
                        n_xor = '0; n_pend_type = '0; n_pend_len = '0; n_pend_pos = '0;
                    end else begin
                        n_pend_type = b;
                        n_xor       = r_xor ^ b;
                        n_phase     = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (b > 8'(MAX_PAYLOAD)) begin
                        n_cnt_parse = r_cnt_parse + 32'd1;
                        st = ST_PARSE_ERR;
                        n_phase = PH_SYNC0;
                        n_xor = '0; n_pend_type = '0; n_pend_len = '0; n_pend_pos = '0;
                    end else begin
                        n_pend_len = b[5:0];
                        n_pend_pos = '0;
                        n_xor      = r_xor ^ b;
                        n_phase    = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    wr_en      = 1'b1;
                    n_pend_pos = pos_inc;
                    n_xor      = r_xor ^ b;
                    if (pos_inc >= r_pend_len) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    if (b == r_xor) begin
                        st = ST_PACKET_OK;
                        if (r_held_valid) begin
                            n_cnt_over = r_cnt_over + 32'd1;
                            st = ST_OVERWRITE;
                        end
                        n_held_bank  = ~r_held_bank;
                        n_held_type  = r_pend_type;
                        n_held_len   = r_pend_len;
                        n_held_valid = 1'b1;
                        n_cnt_recv   = r_cnt_recv + 32'd1;
                    end else begin
                        n_cnt_check = r_cnt_check + 32'd1;
                        st = ST_CHECK_ERR;
                    end
                    n_phase = PH_SYNC0;
                    n_xor = '0; n_pend_type = '0; n_pend_len = '0; n_pend_pos = '0;
                end
                default: begin
                    n_cnt_parse = r_cnt_parse + 32'd1;
                    st = ST_PARSE_ERR;
                    n_phase = PH_SYNC0;
                    n_xor = '0; n_pend_type = '0; n_pend_len = '0; n_pend_pos = '0;
                end
            endcase

            n_out_valid                = 1'b1;
            n_res                      = '0;
            n_res.status               = st;
            n_res.has_packet           = n_held_valid;
            n_res.last                 = 1'b1;
            n_res.parse_error_count    = n_cnt_parse;
            n_res.checksum_error_count = n_cnt_check;
            n_res.received_count       = n_cnt_recv;
            n_res.overwritten_count    = n_cnt_over;
        end

        if (do_take) begin
            n_res                      = '0;
            n_res.last                 = 1'b1;
            n_res.parse_error_count    = r_cnt_parse;
            n_res.checksum_error_count = r_cnt_check;
            n_res.received_count       = r_cnt_recv;
            n_res.overwritten_count    = r_cnt_over;
            if (!r_held_valid) begin
                n_res.status = ST_NONE;
                n_out_valid  = 1'b1;
            end else if (r_held_len == 6'd0) begin
                n_res.status        = ST_DATA;
                n_res.msg_type      = r_held_type;
                n_out_valid         = 1'b1;
                n_held_valid        = 1'b0;
            end else begin
                n_held_valid = 1'b0;
                rd_en        = 1'b1;
                n_emit_pos   = '0;
                n_state      = B_EMIT;
            end
        end

        if (r_state == B_EMIT && slot_free) begin
            n_out_valid                = 1'b1;
            n_res                      = '0;
            n_res.status               = ST_DATA;
            n_res.msg_type             = r_held_type;
            n_res.payload_length       = r_held_len;
            n_res.payload_byte         = r_rd_data;
            n_res.byte_position        = r_emit_pos[4:0];
            n_res.last                 = (emit_next == r_held_len);
            n_res.parse_error_count    = r_cnt_parse;
            n_res.checksum_error_count = r_cnt_check;
            n_res.received_count       = r_cnt_recv;
            n_res.overwritten_count    = r_cnt_over;
            if (emit_next == r_held_len) begin
                n_state = B_IDLE;
            end else begin
                rd_en      = 1'b1;
                rd_addr    = held_base + AW'(emit_next);
                n_emit_pos = emit_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SYNC0;
            r_xor        <= '0;
            r_pend_type  <= '0;
            r_pend_len   <= '0;
            r_pend_pos   <= '0;
            r_held_bank  <= 1'b0;
            r_held_type  <= '0;
            r_held_len   <= '0;
            r_held_valid <= 1'b0;
            r_cnt_parse  <= '0;
            r_cnt_check  <= '0;
            r_cnt_recv   <= '0;
            r_cnt_over   <= '0;
            r_state      <= B_IDLE;
            r_emit_pos   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_xor        <= n_xor;
            r_pend_type  <= n_pend_type;
            r_pend_len   <= n_pend_len;
            r_pend_pos   <= n_pend_pos;
            r_held_bank  <= n_held_bank;
            r_held_type  <= n_held_type;
            r_held_len   <= n_held_len;
            r_held_valid <= n_held_valid;
            r_cnt_parse  <= n_cnt_parse;
            r_cnt_check  <= n_cnt_check;
            r_cnt_recv   <= n_cnt_recv;
            r_cnt_over   <= n_cnt_over;
            r_state      <= n_state;
            r_emit_pos   <= n_emit_pos;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= b;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_result.valid                = r_out_valid;
    assign o_result.status               = r_res.status;
    assign o_result.has_packet           = r_res.has_packet;
    assign o_result.msg_type             = r_res.msg_type;
    assign o_result.payload_length       = r_res.payload_length;
    assign o_result.payload_byte         = r_res.payload_byte;
    assign o_result.byte_position        = r_res.byte_position;
    assign o_result.last                 = r_res.last;
    assign o_result.parse_error_count    = r_res.parse_error_count;
    assign o_result.checksum_error_count = r_res.checksum_error_count;
    assign o_result.received_count       = r_res.received_count;
    assign o_result.overwritten_count    = r_res.overwritten_count;
endmodule

// File: src/xor_checked_packet_deframer.sv
// Receive-side deframer for a byte stream carrying frames of the form 0xAA, 0x55, version 0x01,
// type, length, payload and an XOR checksum over version, type, length and payload. Each input
// transfer is either one received byte, which yields exactly one result transfer giving the
// parser outcome and the four wrapping event counters, or a take request, which yields the
// latest good packet as one result transfer per payload byte (one transfer for an empty packet
// or when nothing is held). Input transfers pass through a two-entry command queue into a back
// end that handles one command at a time and drives a registered result stage. A take of a
// packet with payload starts with a registered read of the payload memory and then gives one
// result per byte. Message types are accepted only strictly between the two type registers,
// written through the APB port at byte addresses 0 (floor) and 4 (ceiling); the user must write
// them only while the block is idle, which the block itself does not enforce.
module xor_checked_packet_deframer #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    xcpd_item_if.sink     i_item,
    xcpd_result_if.source o_result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import xcpd_pkg::*;

    logic [7:0] r_type_floor;
    logic [7:0] r_type_ceiling;
    logic       cfg_write;
    t_cfg       cfg;
    logic       cmd_valid;
    t_cmd       cmd;
    logic       cmd_pop;

    // Configuration registers: the write lands in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_floor   <= 8'd0;
            r_type_ceiling <= 8'd255;
        end else if (cfg_write) begin
            if (paddr[2] == REG_TYPE_FLOOR) begin
                r_type_floor <= pwdata[7:0];
            end else begin
                r_type_ceiling <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_TYPE_CEILING) begin
            prdata = {24'd0, r_type_ceiling};
        end else begin
            prdata = {24'd0, r_type_floor};
        end
    end

    assign cfg.type_floor   = r_type_floor;
    assign cfg.type_ceiling = r_type_ceiling;

    // The front end queues and classifies transfers; the back end parses, holds and emits.
    xcpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    xcpd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_result    (o_result)
    );
endmodule

// File: tb/xor_checked_packet_deframer_tb.sv
module xor_checked_packet_deframer_tb;
    import xcpd_pkg::*;

    localparam int MAX_PAYLOAD     = 32;
    // Cycles without a transfer on either channel before the run is abandoned.
    // The longest legitimate quiet stretch is the deliberate receiver hold-off.
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int HOLD_OFF_CYCLES = 150;
    // Every command yields at least one result, so the back end is idle soon
    // after the last expected result; a short pause is ample before a write.
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 10;

    // Parser phases of the predictor, in the order a frame is walked.
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SECOND_SYNC,
        PH_VERSION,
        PH_MSG_TYPE,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECKSUM
    } t_phase;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_BAD_HEADER
    } t_frame_kind;

    // One row of the directed table. Where typed is set, the status of the
    // single result is the one written in the row rather than the predicted one.
    typedef struct {
        t_op        op;
        logic [7:0] data;
        bit         typed;
        t_status    want;
    } t_probe;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    xcpd_item_if   cmd_bus ();
    xcpd_result_if result_bus ();

    xor_checked_packet_deframer #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (cmd_bus),
        .o_result(result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: a private copy of the deframer and its two registers.
    logic [7:0]  type_floor;
    logic [7:0]  type_ceiling;
    t_phase      parse_phase;
    logic [7:0]  frame_xor;
    logic [7:0]  frame_type;
    logic [5:0]  frame_length;
    logic [5:0]  frame_position;
    logic [7:0]  payload_store [0:63];
    logic        latest_bank;
    logic [7:0]  latest_type;
    logic [5:0]  latest_length;
    logic        latest_valid;
    logic [31:0] header_faults;
    logic [31:0] sum_faults;
    logic [31:0] good_packets;
    logic [31:0] overwritten_packets;

    t_result     expected_results [$];
    t_result     seen_result;
    t_result     oldest_expected;
    int          mismatches;
    int          quiet_cycles;
    int          items_offered;

    // Pacing controls shared between the sender, the receiver and the sequence.
    bit          idle_on;
    bit          hold_request;
    int          hold_left;
    int          stall_left;

    t_probe      probe_table [0:23];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Gap lengths: one draw in ten picks the long range, the rest the short range.
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(12, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Payload lengths: mostly short, sometimes the full 32 bytes.
    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return $urandom_range(0, 6);
        end else if (roll < 85) begin
            return $urandom_range(7, MAX_PAYLOAD - 1);
        end
        return MAX_PAYLOAD;
    endfunction

    task automatic log_mismatch(string what, t_result want, t_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s: expected st=%0d hp=%0d ty=%02h len=%0d data=%02h pos=%0d last=%0d",
                     what, want.status, want.has_packet, want.msg_type,
                     want.payload_length, want.payload_byte, want.byte_position, want.last);
            $display("    expected counts pe=%0d ce=%0d rx=%0d ow=%0d",
                     want.parse_error_count, want.checksum_error_count,
                     want.received_count, want.overwritten_count);
            $display("    actual   st=%0d hp=%0d ty=%02h len=%0d data=%02h pos=%0d last=%0d",
                     got.status, got.has_packet, got.msg_type, got.payload_length,
                     got.payload_byte, got.byte_position, got.last);
            $display("    actual   counts pe=%0d ce=%0d rx=%0d ow=%0d",
                     got.parse_error_count, got.checksum_error_count,
                     got.received_count, got.overwritten_count);
        end
    endtask

    task automatic queue_result(t_status st, logic [7:0] ty, logic [5:0] len,
                                logic [7:0] data, logic [4:0] pos, logic fin);
        t_result r;
        r.status               = st;
        r.has_packet           = latest_valid;
        r.msg_type             = ty;
        r.payload_length       = len;
        r.payload_byte         = data;
        r.byte_position        = pos;
        r.last                 = fin;
        r.parse_error_count    = header_faults;
        r.checksum_error_count = sum_faults;
        r.received_count       = good_packets;
        r.overwritten_count    = overwritten_packets;
        expected_results.push_back(r);
    endtask

    task automatic restart_frame();
        parse_phase    = PH_HUNT;
        frame_xor      = 8'h00;
        frame_type     = 8'h00;
        frame_length   = 6'd0;
        frame_position = 6'd0;
    endtask

    // Works out the results of one accepted command and updates the private
    // copy of the deframer. Received bytes give one result; a take gives one
    // result per payload byte, or a single one for an empty packet or none.
    task automatic deframe_predict(t_op op, logic [7:0] b);
        t_status st;
        int      k;
        if (op == OP_BYTE) begin
            st = ST_CONSUMED;
            case (parse_phase)
                PH_HUNT: begin
                    if (b == SYNC_FIRST) parse_phase = PH_SECOND_SYNC;
                end
                PH_SECOND_SYNC: begin
                    // A repeated first sync byte keeps the hunt alive.
                    if (b == SYNC_SECOND) begin
                        parse_phase = PH_VERSION;
                    end else if (b != SYNC_FIRST) begin
                        restart_frame();
                    end
                end
                PH_VERSION: begin
                    if (b != FRAME_VERSION) begin
                        header_faults++;
                        restart_frame();
                        st = ST_PARSE_ERR;
                    end else begin
                        frame_xor   = b;
                        parse_phase = PH_MSG_TYPE;
                    end
                end
                PH_MSG_TYPE: begin
                    if (b <= type_floor || b >= type_ceiling) begin
                        header_faults++;
                        restart_frame();
                        st = ST_PARSE_ERR;
                    end else begin
                        frame_type  = b;
                        frame_xor   = frame_xor ^ b;
                        parse_phase = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (b > MAX_PAYLOAD) begin
                        header_faults++;
                        restart_frame();
                        st = ST_PARSE_ERR;
                    end else begin
                        frame_length   = b[5:0];
                        frame_position = 6'd0;
                        frame_xor      = frame_xor ^ b;
                        parse_phase    = (b == 8'h00) ? PH_CHECKSUM : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    // The frame is built in the bank that is not being held.
                    payload_store[{~latest_bank, frame_position[4:0]}] = b;
                    frame_position = frame_position + 6'd1;
                    frame_xor      = frame_xor ^ b;
                    if (frame_position >= frame_length) parse_phase = PH_CHECKSUM;
                end
                PH_CHECKSUM: begin
                    if (b == frame_xor) begin
                        st = ST_PACKET_OK;
                        if (latest_valid) begin
                            overwritten_packets++;
                            st = ST_OVERWRITE;
                        end
                        latest_bank   = ~latest_bank;
                        latest_type   = frame_type;
                        latest_length = frame_length;
                        latest_valid  = 1'b1;
                        good_packets++;
                    end else begin
                        sum_faults++;
                        st = ST_CHECK_ERR;
                    end
                    restart_frame();
                end
                default: begin
                    header_faults++;
                    restart_frame();
                    st = ST_PARSE_ERR;
                end
            endcase
            queue_result(st, 8'h00, 6'd0, 8'h00, 5'd0, 1'b1);
        end else if (!latest_valid) begin
            queue_result(ST_NONE, 8'h00, 6'd0, 8'h00, 5'd0, 1'b1);
        end else begin
            latest_valid = 1'b0;
            if (latest_length == 6'd0) begin
                queue_result(ST_DATA, latest_type, 6'd0, 8'h00, 5'd0, 1'b1);
            end else begin
                for (k = 0; k < latest_length; k++) begin
                    queue_result(ST_DATA, latest_type, latest_length,
                                 payload_store[{latest_bank, k[4:0]}], k[4:0],
                                 (k + 1 == latest_length));
                end
            end
        end
    endtask

    // Offers one command, with a random gap in front of it when idling is on.
    // Entered and left at a rising edge; the command is predicted at the edge
    // at which it is transferred.
    task automatic send_cmd(t_op op, logic [7:0] b);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.operation <= op;
        cmd_bus.rx_byte   <= b;
        // Ready is looked at on the falling edge ahead of the transfer edge, where it is stable.
        @(negedge i_clk);
        while (cmd_bus.ready !== 1'b1) @(negedge i_clk);
        @(posedge i_clk);
        items_offered++;
        deframe_predict(op, b);
    endtask

    // APB write: setup cycle, then the access cycle, which completes at the
    // edge where pready is high. The task then waits for another rising edge
    // before it ends, so that a second write need not touch psel twice in one step.
    task automatic apb_write(logic [2:0] addr, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'h000000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (pready !== 1'b1) @(negedge i_clk);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_TYPE_FLOOR) begin
            type_floor = value;
        end else begin
            type_ceiling = value;
        end
        @(posedge i_clk);
    endtask

    // Stops offering commands and waits until every expected result has
    // arrived, then lets the back end settle into idle.
    task automatic drain();
        cmd_bus.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_type_window(logic [7:0] floor_value, logic [7:0] ceiling_value);
        drain();
        apb_write({REG_TYPE_FLOOR, 2'b00}, floor_value);
        apb_write({REG_TYPE_CEILING, 2'b00}, ceiling_value);
    endtask

    // Sends one frame. Header flaws end the frame at the offending byte, as
    // the deframer resynchronises there; the type flaw uses the register
    // values themselves, which are the nearest types that must be refused.
    task automatic send_frame(t_frame_kind kind);
        logic [7:0] frame_bytes [$];
        logic [7:0] sum;
        logic [7:0] ty;
        int         len;
        int         flaw;
        len  = pick_length();
        flaw = (kind == FRAME_BAD_HEADER) ? $urandom_range(0, 2) : -1;
        if ($urandom_range(0, 7) == 0) frame_bytes.push_back(SYNC_FIRST);
        frame_bytes.push_back(SYNC_FIRST);
        frame_bytes.push_back(SYNC_SECOND);
        if (flaw == 0) begin
            frame_bytes.push_back(FRAME_VERSION ^ 8'($urandom_range(1, 255)));
        end else begin
            frame_bytes.push_back(FRAME_VERSION);
            if (flaw == 1) begin
                ty = ($urandom_range(0, 1) == 0) ? type_floor : type_ceiling;
            end else if (type_ceiling > type_floor + 9'd1) begin
                ty = 8'($urandom_range(type_floor + 1, type_ceiling - 1));
            end else begin
                ty = 8'($urandom_range(0, 255));
            end
            frame_bytes.push_back(ty);
            if (flaw == 2) begin
                frame_bytes.push_back(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
            end else if (flaw < 0) begin
                frame_bytes.push_back(8'(len));
                sum = FRAME_VERSION ^ ty ^ 8'(len);
                repeat (len) begin
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
                    sum = sum ^ frame_bytes[frame_bytes.size() - 1];
                end
                if (kind == FRAME_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
                frame_bytes.push_back(sum);
            end
        end
        foreach (frame_bytes[i]) send_cmd(OP_BYTE, frame_bytes[i]);
    endtask

    // Random traffic: mostly well-formed frames with random content, the rest
    // takes, damaged frames and stray bytes. Optionally asks the receiver for
    // its long hold-off once a given number of commands has gone in.
    task automatic run_random_phase(int quota, int hold_at);
        int start;
        int roll;
        bit hold_asked;
        start      = items_offered;
        hold_asked = 1'b0;
        while (items_offered - start < quota) begin
            if (hold_at >= 0 && !hold_asked && items_offered - start >= hold_at) begin
                hold_request = 1'b1;
                hold_asked   = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 58) begin
                send_frame(FRAME_GOOD);
            end else if (roll < 68) begin
                send_frame(FRAME_BAD_SUM);
            end else if (roll < 76) begin
                send_frame(FRAME_BAD_HEADER);
            end else if (roll < 92) begin
                send_cmd(OP_TAKE, 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 3)) send_cmd(OP_BYTE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Result side: ready is driven at the rising edge. Random stalls when
    // idling is on, and one long hold-off on request, counted here.
    initial begin
        result_bus.ready <= 1'b0;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0) stall_left = gap_len();
            end
        end
    end

    // Result checker. A transfer is seen at the falling edge before the rising edge
    // that completes it, when valid, ready and the payload are all settled.
    always @(negedge i_clk) begin
        if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
            seen_result = {result_bus.status, result_bus.has_packet,
                           result_bus.msg_type, result_bus.payload_length,
                           result_bus.payload_byte, result_bus.byte_position,
                           result_bus.last, result_bus.parse_error_count,
                           result_bus.checksum_error_count, result_bus.received_count,
                           result_bus.overwritten_count};
            if (expected_results.size() == 0) begin
                log_mismatch("result with nothing expected", '0, seen_result);
            end else begin
                oldest_expected = expected_results.pop_front();
                if (seen_result !== oldest_expected) begin
                    log_mismatch("result mismatch", oldest_expected, seen_result);
                end
            end
        end
    end

    // Watchdog: the run is abandoned after too long without any transfer.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if ((cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
                (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("xor_checked_packet_deframer_tb: FAIL");
        $finish;
    end

    // Main sequence.
    initial begin
        i_rst_n           <= 1'b0;
        cmd_bus.valid     <= 1'b0;
        cmd_bus.operation <= OP_BYTE;
        cmd_bus.rx_byte   <= 8'h00;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= 3'd0;
        pwdata            <= 32'h0;
        idle_on       = 1'b1;
        hold_request  = 1'b0;
        mismatches    = 0;
        items_offered = 0;
        type_floor    = 8'h00;
        type_ceiling  = 8'hFF;
        latest_bank   = 1'b0;
        latest_type   = 8'h00;
        latest_length = 6'd0;
        latest_valid  = 1'b0;
        header_faults       = 32'd0;
        sum_faults          = 32'd0;
        good_packets        = 32'd0;
        overwritten_packets = 32'd0;
        restart_frame();

        // Directed rows, written for the widest type window (floor 0,
        // ceiling 255): a take with nothing held, an empty packet reached
        // through a repeated sync byte and then taken, a broken sync, a bad
        // version, a type at the ceiling and a length just above the maximum.
        probe_table = '{
            '{OP_TAKE, 8'h00, 1'b1, ST_NONE},
            '{OP_BYTE, 8'hAA, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'hAA, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'h55, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'h01, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'h80, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'h00, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'h81, 1'b1, ST_PACKET_OK},
            '{OP_TAKE, 8'hFF, 1'b1, ST_DATA},
            '{OP_BYTE, 8'hAA, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'h13, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'hAA, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'h55, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'h02, 1'b1, ST_PARSE_ERR},
            '{OP_BYTE, 8'hAA, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'h55, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'h01, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'hFF, 1'b1, ST_PARSE_ERR},
            '{OP_BYTE, 8'hAA, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'h55, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'h01, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'h10, 1'b1, ST_CONSUMED},
            '{OP_BYTE, 8'h21, 1'b1, ST_PARSE_ERR},
            '{OP_TAKE, 8'h00, 1'b1, ST_NONE}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Both registers are written even though the first window equals
        // the reset values, so that the write path itself is exercised.
        set_type_window(8'h00, 8'hFF);
        foreach (probe_table[i]) begin
            send_cmd(probe_table[i].op, probe_table[i].data);
            if (probe_table[i].typed) begin
                expected_results[expected_results.size() - 1].status = probe_table[i].want;
            end
        end
        // The receiver holds off for a long stretch early in this phase so
        // that the command queue fills and the input is stalled.
        run_random_phase(55, 20);

        // A middle window with no idling on either side.
        set_type_window(8'h40, 8'hC0);
        idle_on = 1'b0;
        run_random_phase(65, -1);

        // A window that admits a single type.
        set_type_window(8'h7F, 8'h81);
        idle_on = 1'b1;
        run_random_phase(50, -1);

        // Extreme window that admits nothing: every header that passes the version check fails on the type.
        set_type_window(8'hFF, 8'h00);
        run_random_phase(25, -1);

        // Low extreme: only type 1 passes.
        set_type_window(8'h00, 8'h02);
        run_random_phase(60, -1);

        drain();
        while (expected_results.size() != 0) begin
            log_mismatch("result never delivered", expected_results.pop_front(), '0);
        end
        if (mismatches == 0) begin
            $display("xor_checked_packet_deframer_tb: PASS");
        end else begin
            $display("xor_checked_packet_deframer_tb: FAIL");
        end
        $finish;
    end

endmodule
